// ===== hdl/union_find_table_top_assert.svh =====
// Assertion macros for the union-find table checker.
// Each macro samples on clk and is disabled while rst is high.
`ifndef UNION_FIND_TABLE_TOP_ASSERT_SVH
`define UNION_FIND_TABLE_TOP_ASSERT_SVH

// Same-cycle implication.
`define UFT_ASSERT_NOW(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// Next-cycle implication.
`define UFT_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

// ===== hdl/uft_pkg.sv =====
`default_nettype none

package uft_pkg;

  localparam int NUM_ELEMENTS = 1024;
  localparam int IDX_W        = 10;
  localparam int SIZE_W       = 11;
  localparam int ADDR_W       = $clog2(NUM_ELEMENTS);

  localparam logic [SIZE_W-1:0] SIZE_ONE = SIZE_W'(1);
  localparam logic [SIZE_W-1:0] SIZE_MAX = {SIZE_W{1'b1}};

  // Operation codes; the unused code behaves as find
  localparam logic [1:0] ACT_MAKE  = 2'd0;
  localparam logic [1:0] ACT_UNION = 2'd1;
  localparam logic [1:0] ACT_FIND  = 2'd2;

  typedef struct packed {
    logic [1:0]       action;
    logic [IDX_W-1:0] node_a;
    logic [IDX_W-1:0] node_b;
  } uft_cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0]  root;
    logic [SIZE_W-1:0] set_size;
    logic              merged;
  } uft_rsp_t;

  // Port requests toward the parent and size memories
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [IDX_W-1:0]  wdata;
  } uft_par_req_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] wdata;
  } uft_siz_req_t;

  // An index at or beyond the table is a fixed singleton
  function automatic logic in_table(input logic [IDX_W-1:0] v);
    return (32'(v) < NUM_ELEMENTS);
  endfunction

  function automatic logic [ADDR_W-1:0] to_addr(input logic [IDX_W-1:0] v);
    return ADDR_W'(v);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/uft_ram.sv =====
`default_nettype none

module uft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port, read-first, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ===== hdl/uft_ctrl.sv =====
`default_nettype none

module uft_ctrl (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire uft_pkg::uft_cmd_t                   cmd,
  output logic                                     done,
  output uft_pkg::uft_rsp_t                        rsp,
  output uft_pkg::uft_par_req_t                    par_req,
  input  wire logic [uft_pkg::IDX_W-1:0]           par_rdata,
  output uft_pkg::uft_siz_req_t                    siz_req,
  input  wire logic [uft_pkg::SIZE_W-1:0]          siz_rdata
);

  typedef enum logic [8:0] {
    S_CLEAR    = 9'b000000001,
    S_IDLE     = 9'b000000010,
    S_WALK_RD  = 9'b000000100,
    S_WALK_CHK = 9'b000001000,
    S_COMP_RD  = 9'b000010000,
    S_COMP_WR  = 9'b000100000,
    S_POST     = 9'b001000000,
    S_SZ_A     = 9'b010000000,
    S_SZ_B     = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  logic [uft_pkg::ADDR_W-1:0] clr_idx;
  logic                       is_union;
  logic                       phase_b;
  logic                       do_merge;
  logic [uft_pkg::IDX_W-1:0]  node_b_q;
  logic [uft_pkg::IDX_W-1:0]  cur;
  logic [uft_pkg::IDX_W-1:0]  start_node;
  logic [uft_pkg::IDX_W-1:0]  found;
  logic [uft_pkg::IDX_W-1:0]  ra;
  logic [uft_pkg::IDX_W-1:0]  rb;
  logic [uft_pkg::SIZE_W-1:0] sa;

  logic                       merge_ok;
  logic                       b_smaller;
  logic [uft_pkg::IDX_W-1:0]  big;
  logic [uft_pkg::IDX_W-1:0]  small_root;
  logic [uft_pkg::SIZE_W:0]   sum_wide;
  logic [uft_pkg::SIZE_W-1:0] sum_sat;
  logic                       walk_a;
  logic                       walk_first;

  assign busy = (state != S_IDLE);

  // Merge only two distinct roots that both live in the table
  assign merge_ok = is_union && (ra != rb) && uft_pkg::in_table(ra) && uft_pkg::in_table(rb);

  // Larger set keeps its root; ties keep node_a's root
  assign b_smaller  = !(sa < siz_rdata);
  assign big        = b_smaller ? ra : rb;
  assign small_root = b_smaller ? rb : ra;
  assign sum_wide   = {1'b0, sa} + {1'b0, siz_rdata};
  assign sum_sat    = sum_wide[uft_pkg::SIZE_W] ? uft_pkg::SIZE_MAX
                                                : sum_wide[uft_pkg::SIZE_W-1:0];

  // Decide where a new item starts its walk
  assign walk_a     = uft_pkg::in_table(cmd.node_a);
  assign walk_first = (cmd.action == uft_pkg::ACT_UNION)
                      ? (walk_a || uft_pkg::in_table(cmd.node_b)) : walk_a;

  // Drive memory ports per state
  always_comb begin
    par_req = '0;
    siz_req = '0;
    case (state)
      S_CLEAR: begin
        par_req.we    = 1'b1;
        par_req.addr  = clr_idx;
        par_req.wdata = uft_pkg::IDX_W'(clr_idx);
        siz_req.we    = 1'b1;
        siz_req.addr  = clr_idx;
        siz_req.wdata = uft_pkg::SIZE_ONE;
      end
      S_IDLE: begin
        if (start && (cmd.action == uft_pkg::ACT_MAKE) && walk_a) begin
          par_req.we    = 1'b1;
          par_req.addr  = uft_pkg::to_addr(cmd.node_a);
          par_req.wdata = cmd.node_a;
          siz_req.we    = 1'b1;
          siz_req.addr  = uft_pkg::to_addr(cmd.node_a);
          siz_req.wdata = uft_pkg::SIZE_ONE;
        end
      end
      S_WALK_RD: begin
        par_req.addr = uft_pkg::to_addr(cur);
      end
      S_COMP_RD: begin
        par_req.addr = uft_pkg::to_addr(cur);
      end
      S_COMP_WR: begin
        par_req.we    = 1'b1;
        par_req.addr  = uft_pkg::to_addr(cur);
        par_req.wdata = found;
      end
      S_POST: begin
        siz_req.addr = uft_pkg::to_addr(ra);
      end
      S_SZ_A: begin
        siz_req.addr = uft_pkg::to_addr(rb);
      end
      S_SZ_B: begin
        par_req.we    = 1'b1;
        par_req.addr  = uft_pkg::to_addr(small_root);
        par_req.wdata = big;
        siz_req.we    = 1'b1;
        siz_req.addr  = uft_pkg::to_addr(big);
        siz_req.wdata = sum_sat;
      end
      default: begin
        par_req = '0;
        siz_req = '0;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_idx == uft_pkg::ADDR_W'(uft_pkg::NUM_ELEMENTS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start && (cmd.action != uft_pkg::ACT_MAKE)) begin
          state_next = walk_first ? S_WALK_RD : S_POST;
        end
      end
      S_WALK_RD: state_next = S_WALK_CHK;
      S_WALK_CHK: begin
        state_next = (par_rdata == cur) ? S_COMP_RD : S_WALK_RD;
      end
      S_COMP_RD: begin
        if (cur != found) begin
          state_next = S_COMP_WR;
        end else if (!phase_b && is_union && uft_pkg::in_table(node_b_q)) begin
          state_next = S_WALK_RD;
        end else begin
          state_next = S_POST;
        end
      end
      S_COMP_WR: state_next = S_COMP_RD;
      S_POST: begin
        state_next = uft_pkg::in_table(ra) ? S_SZ_A : S_IDLE;
      end
      S_SZ_A: state_next = do_merge ? S_SZ_B : S_IDLE;
      S_SZ_B: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Control and working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_idx <= '0;
      done    <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
        end
        S_IDLE: begin
          if (start) begin
            is_union <= (cmd.action == uft_pkg::ACT_UNION);
            node_b_q <= cmd.node_b;
            ra       <= cmd.node_a;
            rb       <= cmd.node_b;
            if (cmd.action == uft_pkg::ACT_MAKE) begin
              done         <= 1'b1;
              rsp.root     <= cmd.node_a;
              rsp.set_size <= uft_pkg::SIZE_ONE;
              rsp.merged   <= 1'b0;
            end else if ((cmd.action == uft_pkg::ACT_UNION) && !walk_a) begin
              cur        <= cmd.node_b;
              start_node <= cmd.node_b;
              phase_b    <= 1'b1;
            end else begin
              cur        <= cmd.node_a;
              start_node <= cmd.node_a;
              phase_b    <= 1'b0;
            end
          end
        end
        S_WALK_CHK: begin
          if (par_rdata == cur) begin
            found <= cur;
            cur   <= start_node;
          end else begin
            cur <= par_rdata;
          end
        end
        S_COMP_RD: begin
          // Path fully rewritten: record the root, then walk node_b if needed
          if (cur == found) begin
            if (!phase_b) begin
              ra <= found;
              if (is_union && uft_pkg::in_table(node_b_q)) begin
                phase_b    <= 1'b1;
                cur        <= node_b_q;
                start_node <= node_b_q;
              end
            end else begin
              rb <= found;
            end
          end
        end
        S_COMP_WR: begin
          cur <= par_rdata;
        end
        S_POST: begin
          do_merge <= merge_ok;
          if (!uft_pkg::in_table(ra)) begin
            done         <= 1'b1;
            rsp.root     <= ra;
            rsp.set_size <= uft_pkg::SIZE_ONE;
            rsp.merged   <= 1'b0;
          end
        end
        S_SZ_A: begin
          sa <= siz_rdata;
          if (!do_merge) begin
            done         <= 1'b1;
            rsp.root     <= ra;
            rsp.set_size <= siz_rdata;
            rsp.merged   <= 1'b0;
          end
        end
        S_SZ_B: begin
          done         <= 1'b1;
          rsp.root     <= big;
          rsp.set_size <= sum_sat;
          rsp.merged   <= 1'b1;
        end
        default: begin
          done <= 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/union_find_table_top.sv =====
// Union-find table, union by size with path compression; one operation per beat.
// Make: result in the cycle after the beat; the next beat is taken in the following cycle.
// Find: read parents from node_a up to the root, rewrite each node on the path to point
// at it, then read the root's size; union walks node_b too, plus a write on a merge.
// Next beat is taken in the cycle the result strobes; done cannot be stalled.
// Synchronous reset starts a clearing pass of both 1024-entry tables; busy stays high.
`default_nettype none

module union_find_table_top (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire uft_pkg::uft_cmd_t cmd,
  output logic                   done,
  output uft_pkg::uft_rsp_t      rsp
);

  uft_pkg::uft_par_req_t             par_req;
  uft_pkg::uft_siz_req_t             siz_req;
  logic [uft_pkg::IDX_W-1:0]         par_rdata;
  logic [uft_pkg::SIZE_W-1:0]        siz_rdata;

  uft_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .done      (done),
    .rsp       (rsp),
    .par_req   (par_req),
    .par_rdata (par_rdata),
    .siz_req   (siz_req),
    .siz_rdata (siz_rdata)
  );

  // Parent links
  uft_ram #(
    .WIDTH (uft_pkg::IDX_W),
    .DEPTH (uft_pkg::NUM_ELEMENTS)
  ) u_parent_ram (
    .clk   (clk),
    .we    (par_req.we),
    .addr  (par_req.addr),
    .wdata (par_req.wdata),
    .rdata (par_rdata)
  );

  // Set sizes held at roots
  uft_ram #(
    .WIDTH (uft_pkg::SIZE_W),
    .DEPTH (uft_pkg::NUM_ELEMENTS)
  ) u_size_ram (
    .clk   (clk),
    .we    (siz_req.we),
    .addr  (siz_req.addr),
    .wdata (siz_req.wdata),
    .rdata (siz_rdata)
  );

endmodule

`default_nettype wire

// ===== hdl/uft_checker.sv =====
`default_nettype none

`include "union_find_table_top_assert.svh"

module uft_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire logic              busy,
  input wire uft_pkg::uft_cmd_t cmd,
  input wire logic              done,
  input wire uft_pkg::uft_rsp_t rsp
);

  // Make answers in the next cycle with a fresh singleton
  `UFT_ASSERT_NEXT(a_make_resp, start && !busy && (cmd.action == uft_pkg::ACT_MAKE), done && (rsp.root == $past(cmd.node_a)) && (rsp.set_size == uft_pkg::SIZE_ONE) && !rsp.merged, "make beat did not answer a singleton next cycle")

  // Any other beat holds the block busy
  `UFT_ASSERT_NEXT(a_walk_busy, start && !busy && (cmd.action != uft_pkg::ACT_MAKE), busy, "find or union beat did not raise busy")

  // Result only as the block goes idle
  `UFT_ASSERT_NOW(a_done_idle, done, !busy, "result strobed while busy")

  // Reported sizes are never zero
  `UFT_ASSERT_NOW(a_size_nonzero, done, rsp.set_size != '0, "result set size is zero")

  // A merge yields a set of at least two
  `UFT_ASSERT_NOW(a_merge_size, done && rsp.merged, rsp.set_size >= uft_pkg::SIZE_W'(2), "merged result with size below two")

endmodule

bind union_find_table_top uft_checker u_uft_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .cmd   (cmd),
  .done  (done),
  .rsp   (rsp)
);

`default_nettype wire

// ===== tb/sv/tb_union_find_table_top.sv =====
`default_nettype none

module tb_union_find_table_top;
  timeunit 1ns;
  timeprecision 1ps;

  import uft_pkg::*;

  // The unused operation code; the block treats it as a find
  localparam logic [1:0] ACT_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 128;
  localparam int MAX_SHOWN     = 10;
  localparam int RANDOM_OPS    = 940;
  localparam int GROW_SPAN     = 64;
  localparam int GROW_ROUNDS   = 32;

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  uft_cmd_t cmd;
  logic     done;
  uft_rsp_t rsp;

  union_find_table_top dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .done(done),
    .rsp(rsp)
  );

  // Predicted contents of the parent and size tables
  logic [IDX_W-1:0]  link_mem  [NUM_ELEMENTS];
  logic [SIZE_W-1:0] count_mem [NUM_ELEMENTS];

  // Results predicted for accepted beats, oldest first
  uft_rsp_t pending_rsp [$];

  int n_beats     = 0;
  int n_results   = 0;
  int n_merges    = 0;
  int n_saturated = 0;
  int n_bad       = 0;
  int n_by_action [4] = '{0, 0, 0, 0};

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic is_stored(input logic [IDX_W-1:0] v);
    return int'(v) < NUM_ELEMENTS;
  endfunction

  function automatic void clear_sets();
    for (int i = 0; i < NUM_ELEMENTS; i++) begin
      link_mem[i]  = IDX_W'(i);
      count_mem[i] = SIZE_ONE;
    end
  endfunction

  // Walk to the root, then point every node on the walked path at it
  function automatic logic [IDX_W-1:0] climb_and_flatten(input logic [IDX_W-1:0] v);
    logic [IDX_W-1:0] top;
    logic [IDX_W-1:0] cur;
    logic [IDX_W-1:0] nxt;
    int steps;
    if (!is_stored(v)) return v;
    top = v;
    steps = 0;
    while (link_mem[top] != top && steps < NUM_ELEMENTS) begin
      top = link_mem[top];
      steps++;
    end
    cur = v;
    steps = 0;
    while (cur != top && steps < NUM_ELEMENTS) begin
      nxt = link_mem[cur];
      link_mem[cur] = top;
      cur = nxt;
      steps++;
    end
    return top;
  endfunction

  function automatic logic [SIZE_W-1:0] recorded_size(input logic [IDX_W-1:0] r);
    return is_stored(r) ? count_mem[r] : SIZE_ONE;
  endfunction

  // Apply one operation to the predicted tables and return its result
  function automatic uft_rsp_t apply_op(input uft_cmd_t c);
    uft_rsp_t r;
    logic [IDX_W-1:0] ra;
    logic [IDX_W-1:0] rb;
    logic [IDX_W-1:0] big;
    logic [IDX_W-1:0] little;
    int total;
    r = '0;
    case (c.action)
      ACT_MAKE: begin
        if (is_stored(c.node_a)) begin
          link_mem[c.node_a]  = c.node_a;
          count_mem[c.node_a] = SIZE_ONE;
        end
        r.root     = c.node_a;
        r.set_size = SIZE_ONE;
      end
      ACT_UNION: begin
        ra = climb_and_flatten(c.node_a);
        rb = climb_and_flatten(c.node_b);
        if (ra != rb && is_stored(ra) && is_stored(rb)) begin
          // Hang the smaller set under the larger; a tie keeps node_a's root
          big    = ra;
          little = rb;
          if (count_mem[ra] < count_mem[rb]) begin
            big    = rb;
            little = ra;
          end
          link_mem[little] = big;
          total = int'(count_mem[big]) + int'(count_mem[little]);
          count_mem[big] = (total > int'(SIZE_MAX)) ? SIZE_MAX : SIZE_W'(total);
          r.merged = 1'b1;
          r.root   = big;
        end else begin
          r.root = ra;
        end
        r.set_size = recorded_size(r.root);
      end
      default: begin
        r.root     = climb_and_flatten(c.node_a);
        r.set_size = recorded_size(r.root);
      end
    endcase
    return r;
  endfunction

  // Present one beat and hold it until the block takes it
  task automatic issue(input uft_cmd_t c);
    @(negedge clk);
    start = 1'b1;
    cmd   = c;
    do @(posedge clk); while (busy);
    pending_rsp.push_back(apply_op(c));
    n_beats++;
    n_by_action[c.action]++;
  endtask

  // Drop start for a number of cycles, with noise on the command bus
  task automatic pause(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start = 1'b0;
      cmd   = $bits(uft_cmd_t)'($urandom);
    end
  endtask

  // Hold off until every predicted result has come, then let the block settle
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic report_bad(input string what, input uft_rsp_t want, input uft_rsp_t got);
    n_bad++;
    if (n_bad <= MAX_SHOWN)
      $display("%0t: %s: expected root %0d size %0d merged %0d, got root %0d size %0d merged %0d",
               $realtime, what, want.root, want.set_size, want.merged,
               got.root, got.set_size, got.merged);
  endtask

  // Check each result beat against the oldest prediction
  always @(posedge clk) begin : check_rsp
    uft_rsp_t want;
    if (!rst && done) begin
      n_results++;
      if (rsp.merged) n_merges++;
      if (rsp.set_size == SIZE_MAX) n_saturated++;
      if (pending_rsp.size() == 0) begin
        report_bad("result with nothing pending", '0, rsp);
      end else begin
        want = pending_rsp.pop_front();
        if (rsp.root != want.root) report_bad("root mismatch", want, rsp);
        else if (rsp.set_size != want.set_size) report_bad("set_size mismatch", want, rsp);
        else if (rsp.merged != want.merged) report_bad("merged mismatch", want, rsp);
      end
    end
  end

  // Extremes, every operation and the odd cases, from the cleared tables
  task automatic test_directed();
    issue('{ACT_MAKE,  10'd0,     10'd1023});
    issue('{ACT_MAKE,  10'd1023,  10'd0});
    issue('{ACT_FIND,  10'd0,     10'd0});
    pause(1);
    issue('{ACT_FIND,  10'd1023,  10'd1023});
    issue('{ACT_SPARE, 10'd1023,  10'd0});
    // first merge, then the same pair reversed and a node with itself: no merge
    issue('{ACT_UNION, 10'd0,     10'd1023});
    issue('{ACT_UNION, 10'd1023,  10'd0});
    issue('{ACT_UNION, 10'd5,     10'd5});
    pause(3);
    issue('{ACT_UNION, 10'h155,   10'h2AA});
    // equal sizes: node_a's root stays the root
    issue('{ACT_UNION, 10'h2AA,   10'd0});
    issue('{ACT_FIND,  10'd1023,  10'h3FF});
    issue('{ACT_FIND,  10'd0,     10'd0});
    // make on a root that still has children pointing at it
    issue('{ACT_MAKE,  10'h155,   10'h2AA});
    issue('{ACT_FIND,  10'd1023,  10'd0});
    issue('{ACT_UNION, 10'd7,     10'h155});
    issue('{ACT_SPARE, 10'h2AA,   10'h155});
    // node_a's set is the smaller one
    issue('{ACT_UNION, 10'd9,     10'd7});
    issue('{ACT_MAKE,  10'd1023,  10'd1023});
    issue('{ACT_FIND,  10'd9,     10'd0});
    issue('{ACT_UNION, 10'd1023,  10'd9});
  endtask

  function automatic uft_cmd_t random_op(input int base, input int span);
    uft_cmd_t c;
    int pick;
    pick = $urandom_range(99);
    if (pick < 40)      c.action = ACT_UNION;
    else if (pick < 72) c.action = ACT_FIND;
    else if (pick < 86) c.action = ACT_MAKE;
    else if (pick < 92) c.action = ACT_SPARE;
    else                c.action = 2'($urandom);
    c.node_a = IDX_W'(base + $urandom_range(span - 1));
    c.node_b = IDX_W'(base + $urandom_range(span - 1));
    if ($urandom_range(9) == 0) c.node_a = IDX_W'($urandom);
    if ($urandom_range(9) == 0) c.node_b = IDX_W'($urandom);
    return c;
  endfunction

  // Bursts of operations on a window of elements, mostly narrow, so unions build real trees
  task automatic test_random_ops(input int count);
    int base;
    int span;
    int burst;
    int sent;
    sent = 0;
    while (sent < count) begin
      base = $urandom_range(NUM_ELEMENTS - 1);
      case ($urandom_range(4))
        0:       span = 4;
        1:       span = 16;
        2:       span = 64;
        3:       span = 256;
        default: span = NUM_ELEMENTS;
      endcase
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst && sent < count; i++) begin
        issue(random_op(base, span));
        sent++;
        if (sent == count / 2) drain();
      end
      if ($urandom_range(3) != 0) pause($urandom_range(1, 12));
    end
  endtask

  // Rebuild a window of singletons, join it under element 0, then grow the
  // recorded size past the window by remaking leaves and joining them back
  task automatic test_size_growth();
    for (int i = 0; i < GROW_SPAN; i++)
      issue('{ACT_MAKE, IDX_W'(i), IDX_W'($urandom)});
    for (int i = 1; i < GROW_SPAN; i++)
      issue('{ACT_UNION, IDX_W'(0), IDX_W'(i)});
    for (int j = 0; j < GROW_ROUNDS; j++) begin
      issue('{ACT_MAKE, IDX_W'(1 + j % (GROW_SPAN - 1)), IDX_W'($urandom)});
      issue('{ACT_UNION, IDX_W'(0), IDX_W'(1 + j % (GROW_SPAN - 1))});
    end
    issue('{ACT_FIND, IDX_W'(GROW_SPAN - 1), IDX_W'(0)});
  endtask

  initial begin
    rst   = 1'b1;
    start = 1'b0;
    cmd   = '0;
    clear_sets();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    drain();
    test_random_ops(RANDOM_OPS);
    drain();
    test_size_growth();
    drain();

    $display("covered %0d beats: %0d make, %0d union, %0d find, %0d spare-code find",
             n_beats, n_by_action[ACT_MAKE], n_by_action[ACT_UNION],
             n_by_action[ACT_FIND], n_by_action[ACT_SPARE]);
    $display("checked %0d results, %0d merges, %0d at saturated size, %0d mismatches",
             n_results, n_merges, n_saturated, n_bad);
    if (n_bad == 0) begin
      $display("tb_union_find_table_top passed");
    end else begin
      $display("tb_union_find_table_top failed");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #(50_000_000);
    $display("tb_union_find_table_top failed");
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+hdl
hdl/uft_pkg.sv
hdl/uft_ram.sv
hdl/uft_ctrl.sv
hdl/union_find_table_top.sv
hdl/uft_checker.sv
tb/sv/tb_union_find_table_top.sv
